>>> rtl/brq_pkg.sv
package brq_pkg;

   localparam logic [2:0] CMD_WRITE   = 3'd0;
   localparam logic [2:0] CMD_READ    = 3'd1;
   localparam logic [2:0] CMD_DISCARD = 3'd2;
   localparam logic [2:0] CMD_PEEK    = 3'd3;
   localparam logic [2:0] CMD_COPY    = 3'd4;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN
   } brq_state_type;

   typedef struct packed {
      logic accept;
      logic step;
      logic clear;
   } brq_cmd_type;

   typedef struct packed {
      logic go_burst;
      logic last_beat;
      logic clear_last;
   } brq_status_type;

endpackage

>>> rtl/byte_ring_queue_with_peek.sv
// write, discard and rejected commands: one beat a cycle, result one cycle after start
// read, copy and peek: 1 + n cycles for n bytes, first byte two cycles after start,
// then one byte a cycle from the registered store read port
// after reset busy stays high for DEPTH cycles while the store is cleared
// results are strobed for one cycle each; the receiver cannot stall
module byte_ring_queue_with_peek #(
   parameter int DEPTH     = 256,
   parameter int MAX_BURST = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_command,
   input  logic [7:0] req_write_data,
   input  logic [8:0] req_count,
   input  logic [7:0] req_offset,
   output logic       rsp_strobe,
   output logic [7:0] rsp_read_data,
   output logic       rsp_status,
   output logic [8:0] rsp_level,
   output logic       rsp_empty_res,
   output logic       rsp_full_res,
   output logic       rsp_last
);

   brq_pkg::brq_cmd_type    cmd;
   brq_pkg::brq_status_type stat;

   brq_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .stat (stat),
      .cmd  (cmd),
      .busy (busy)
   );

   brq_datapath #(
      .DEPTH    (DEPTH),
      .MAX_BURST(MAX_BURST)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_command   (req_command),
      .req_write_data(req_write_data),
      .req_count     (req_count),
      .req_offset    (req_offset),
      .rsp_strobe    (rsp_strobe),
      .rsp_read_data (rsp_read_data),
      .rsp_status    (rsp_status),
      .rsp_level     (rsp_level),
      .rsp_empty_res (rsp_empty_res),
      .rsp_full_res  (rsp_full_res),
      .rsp_last      (rsp_last)
   );

endmodule

>>> rtl/brq_ram.sv
module brq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/brq_ctrl.sv
module brq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  brq_pkg::brq_status_type stat,
   output brq_pkg::brq_cmd_type    cmd,
   output logic                    busy
);

   brq_pkg::brq_state_type state_ff;
   brq_pkg::brq_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brq_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         brq_pkg::ST_CLEAR: begin
            if (stat.clear_last) begin
               state_in = brq_pkg::ST_IDLE;
            end
         end
         brq_pkg::ST_IDLE: begin
            if (start && stat.go_burst) begin
               state_in = brq_pkg::ST_RUN;
            end
         end
         brq_pkg::ST_RUN: begin
            if (stat.last_beat) begin
               state_in = brq_pkg::ST_IDLE;
            end
         end
         default: state_in = brq_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd.accept = 1'b0;
      cmd.step   = 1'b0;
      cmd.clear  = 1'b0;
      busy       = 1'b1;
      unique case (state_ff)
         brq_pkg::ST_CLEAR: cmd.clear = 1'b1;
         brq_pkg::ST_IDLE: begin
            busy       = 1'b0;
            cmd.accept = start;
         end
         brq_pkg::ST_RUN: cmd.step = 1'b1;
         default: busy = 1'b1;
      endcase
   end

endmodule

>>> rtl/brq_datapath.sv
module brq_datapath #(
   parameter int DEPTH     = 256,
   parameter int MAX_BURST = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  brq_pkg::brq_cmd_type    cmd,
   output brq_pkg::brq_status_type stat,
   input  logic [2:0]              req_command,
   input  logic [7:0]              req_write_data,
   input  logic [8:0]              req_count,
   input  logic [7:0]              req_offset,
   output logic                    rsp_strobe,
   output logic [7:0]              rsp_read_data,
   output logic                    rsp_status,
   output logic [8:0]              rsp_level,
   output logic                    rsp_empty_res,
   output logic                    rsp_full_res,
   output logic                    rsp_last
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW = $clog2(DEPTH + 1);
   localparam int SW = ((FW > 9) ? FW : 9) + 1;
   localparam int BW = $clog2(MAX_BURST + 1);

   logic [AW-1:0] head_ff, tail_ff, ptr_ff, clr_ff;
   logic [FW-1:0] fill_ff;
   logic          accepted_ff;
   logic [BW-1:0] cnt_ff;
   logic          strobe_ff, last_ff, memsel_ff, status_ff, empty_ff, full_ff;
   logic [8:0]    level_ff;

   logic [SW-1:0] fill_w, cnt_w, off_w, head_sum, head_adv, off_mod, start_sum;
   logic [SW-1:0] fill_next;
   logic [AW-1:0] tail_adv, start_addr, ptr_adv;
   logic          acc_new, acc_eff, do_write, status_in, go_burst, head_move;
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [7:0]    ram_wr_data, ram_rd_data;

   function automatic logic [SW-1:0] mod_depth(input logic [7:0] value);
      logic [31:0] r;
      r = 32'(value);
      for (int i = 7; i >= 0; i--) begin
         if (r >= (32'(DEPTH) << i)) begin
            r = r - (32'(DEPTH) << i);
         end
      end
      return SW'(r);
   endfunction

   assign fill_w   = SW'(fill_ff);
   assign cnt_w    = SW'(req_count);
   assign off_w    = SW'(req_offset);
   assign head_sum = SW'(head_ff) + cnt_w;
   assign head_adv = (head_sum >= SW'(DEPTH)) ? head_sum - SW'(DEPTH) : head_sum;
   assign off_mod  = mod_depth(req_offset);
   assign start_sum = SW'(head_ff) + off_mod;
   assign start_addr = AW'((start_sum >= SW'(DEPTH)) ? start_sum - SW'(DEPTH)
                                                     : start_sum);
   assign tail_adv = (tail_ff == AW'(DEPTH - 1)) ? '0 : tail_ff + AW'(1);
   assign ptr_adv  = (ptr_ff == AW'(DEPTH - 1)) ? '0 : ptr_ff + AW'(1);
   assign acc_new  = (fill_w + cnt_w) <= SW'(DEPTH);
   assign acc_eff  = (req_offset == 8'd0) ? acc_new : accepted_ff;

   always_comb begin
      do_write  = 1'b0;
      status_in = 1'b1;
      go_burst  = 1'b0;
      head_move = 1'b0;
      fill_next = fill_w;
      unique case (req_command)
         brq_pkg::CMD_WRITE: begin
            if (acc_eff && ({1'b0, req_offset} < req_count) && (fill_w < SW'(DEPTH))) begin
               do_write  = 1'b1;
               status_in = 1'b0;
               fill_next = fill_w + SW'(1);
            end
         end
         brq_pkg::CMD_READ: begin
            if (!((req_count > 9'(MAX_BURST)) || (cnt_w > fill_w))) begin
               status_in = 1'b0;
               if (req_count != 9'd0) begin
                  go_burst  = 1'b1;
                  head_move = 1'b1;
                  fill_next = fill_w - cnt_w;
               end
            end
         end
         brq_pkg::CMD_DISCARD: begin
            if (cnt_w <= fill_w) begin
               status_in = 1'b0;
               head_move = 1'b1;
               fill_next = fill_w - cnt_w;
            end
         end
         brq_pkg::CMD_PEEK: begin
            if (off_w < fill_w) begin
               status_in = 1'b0;
               go_burst  = 1'b1;
            end
         end
         brq_pkg::CMD_COPY: begin
            if (req_count <= 9'(MAX_BURST)) begin
               status_in = 1'b0;
               go_burst  = req_count != 9'd0;
            end
         end
         default: status_in = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         fill_ff     <= '0;
         accepted_ff <= 1'b0;
         clr_ff      <= '0;
         strobe_ff   <= 1'b0;
         memsel_ff   <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         if (cmd.clear) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (cmd.accept) begin
            if (req_command == brq_pkg::CMD_WRITE) begin
               accepted_ff <= acc_eff;
            end
            if (do_write) begin
               tail_ff <= tail_adv;
            end
            if (head_move) begin
               head_ff <= AW'(head_adv);
            end
            fill_ff   <= FW'(fill_next);
            strobe_ff <= !go_burst;
            memsel_ff <= 1'b0;
         end
         if (cmd.step) begin
            strobe_ff <= 1'b1;
            memsel_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         status_ff <= status_in;
         level_ff  <= fill_next[8:0];
         empty_ff  <= fill_next == '0;
         full_ff   <= fill_next >= SW'(DEPTH);
         last_ff   <= 1'b1;
         if (req_command == brq_pkg::CMD_PEEK) begin
            cnt_ff <= BW'(1);
         end else begin
            cnt_ff <= BW'(req_count);
         end
         if (req_command == brq_pkg::CMD_READ) begin
            ptr_ff <= head_ff;
         end else begin
            ptr_ff <= start_addr;
         end
      end
      if (cmd.step) begin
         ptr_ff  <= ptr_adv;
         cnt_ff  <= cnt_ff - BW'(1);
         last_ff <= cnt_ff == BW'(1);
      end
   end

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = tail_ff;
      ram_wr_data = req_write_data;
      if (cmd.clear) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_ff;
         ram_wr_data = 8'd0;
      end else if (cmd.accept && do_write) begin
         ram_wr_en = 1'b1;
      end
   end

   brq_ram #(
      .WIDTH(8),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (cmd.step),
      .rd_addr(ptr_ff),
      .rd_data(ram_rd_data)
   );

   assign stat.go_burst   = go_burst;
   assign stat.last_beat  = cnt_ff == BW'(1);
   assign stat.clear_last = clr_ff == AW'(DEPTH - 1);

   assign rsp_strobe    = strobe_ff;
   assign rsp_read_data = memsel_ff ? ram_rd_data : 8'd0;
   assign rsp_status    = status_ff;
   assign rsp_level     = level_ff;
   assign rsp_empty_res = empty_ff;
   assign rsp_full_res  = full_ff;
   assign rsp_last      = last_ff;

endmodule

>>> sim/tb_top.sv
module tb_top;

   localparam int RING_DEPTH = 256;
   localparam int BURST_MAX = 64;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 100;
   localparam int MAX_GAP = 60;
   localparam logic [2:0] CMD_FIRST_UNUSED = brq_pkg::CMD_COPY + 3'd1;
   localparam logic [2:0] CMD_MAX_CODE = 3'd7;

   typedef struct {
      logic [7:0] read_data;
      logic       status;
      logic [8:0] level;
      logic       empty_res;
      logic       full_res;
      logic       last;
   } beat_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       start;
   logic       busy;
   logic [2:0] req_command;
   logic [7:0] req_write_data;
   logic [8:0] req_count;
   logic [7:0] req_offset;
   logic       rsp_strobe;
   logic [7:0] rsp_read_data;
   logic       rsp_status;
   logic [8:0] rsp_level;
   logic       rsp_empty_res;
   logic       rsp_full_res;
   logic       rsp_last;

   // mirror of the queue contents
   logic [7:0] ring_mem [RING_DEPTH];
   int         ring_head;
   int         ring_tail;
   int         ring_fill;
   bit         burst_ok;

   beat_type   expected_beats [$];
   int         mismatch_count = 0;
   int         beats_checked = 0;
   int         items_sent = 0;
   int         cycle_count = 0;
   int         sender_idle_pct = 0;

   byte_ring_queue_with_peek #(
      .DEPTH(RING_DEPTH),
      .MAX_BURST(BURST_MAX)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_command(req_command),
      .req_write_data(req_write_data),
      .req_count(req_count),
      .req_offset(req_offset),
      .rsp_strobe(rsp_strobe),
      .rsp_read_data(rsp_read_data),
      .rsp_status(rsp_status),
      .rsp_level(rsp_level),
      .rsp_empty_res(rsp_empty_res),
      .rsp_full_res(rsp_full_res),
      .rsp_last(rsp_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string text);
      mismatch_count++;
      $display("ERROR at %0t: %s", $time, text);
   endtask

   task automatic compare_field(input string name, input logic [8:0] got,
                                input logic [8:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("beat %0d %s got %0h expected %0h",
                                   beats_checked, name, got, want));
      end
   endtask

   function automatic void expect_beat(input logic [7:0] data, input logic status,
                                       input logic last);
      beat_type b;
      b.read_data = data;
      b.status = status;
      b.level = 9'(ring_fill);
      b.empty_res = (ring_fill == 0);
      b.full_res = (ring_fill >= RING_DEPTH);
      b.last = last;
      expected_beats.push_back(b);
   endfunction

   // queue behavior for one accepted command, pushes the beats it produces
   task automatic ring_model_apply(input logic [2:0] cmd, input logic [7:0] wdata,
                                   input logic [8:0] cnt, input logic [7:0] off);
      logic [7:0] popped [BURST_MAX];
      logic       st;
      int         k;
      st = 1'b1;
      case (cmd)
         brq_pkg::CMD_WRITE: begin
            if (off == 0) burst_ok = (ring_fill + cnt <= RING_DEPTH);
            if (burst_ok && off < cnt && ring_fill < RING_DEPTH) begin
               ring_mem[ring_tail] = wdata;
               ring_tail = (ring_tail + 1) % RING_DEPTH;
               ring_fill++;
               st = 1'b0;
            end
            expect_beat(8'h00, st, 1'b1);
         end
         brq_pkg::CMD_READ: begin
            if (cnt > BURST_MAX || cnt > ring_fill) begin
               expect_beat(8'h00, 1'b1, 1'b1);
            end else if (cnt == 0) begin
               expect_beat(8'h00, 1'b0, 1'b1);
            end else begin
               for (k = 0; k < cnt; k++) begin
                  popped[k] = ring_mem[ring_head];
                  ring_head = (ring_head + 1) % RING_DEPTH;
               end
               ring_fill -= cnt;
               for (k = 0; k < cnt; k++) expect_beat(popped[k], 1'b0, k == cnt - 1);
            end
         end
         brq_pkg::CMD_DISCARD: begin
            if (cnt <= ring_fill) begin
               ring_head = (ring_head + cnt) % RING_DEPTH;
               ring_fill -= cnt;
               st = 1'b0;
            end
            expect_beat(8'h00, st, 1'b1);
         end
         brq_pkg::CMD_PEEK: begin
            if (off >= ring_fill) expect_beat(8'h00, 1'b1, 1'b1);
            else expect_beat(ring_mem[(ring_head + off) % RING_DEPTH], 1'b0, 1'b1);
         end
         brq_pkg::CMD_COPY: begin
            if (cnt > BURST_MAX) begin
               expect_beat(8'h00, 1'b1, 1'b1);
            end else if (cnt == 0) begin
               expect_beat(8'h00, 1'b0, 1'b1);
            end else begin
               for (k = 0; k < cnt; k++) begin
                  expect_beat(ring_mem[(ring_head + off + k) % RING_DEPTH], 1'b0,
                              k == cnt - 1);
               end
            end
         end
         default: expect_beat(8'h00, 1'b1, 1'b1);
      endcase
   endtask

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_cmd(input logic [2:0] cmd, input logic [7:0] wdata,
                           input logic [8:0] cnt, input logic [7:0] off);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_command <= cmd;
      req_write_data <= wdata;
      req_count <= cnt;
      req_offset <= off;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      ring_model_apply(cmd, wdata, cnt, off);
      items_sent++;
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      beat_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_beats.size() == 0) begin
            report_mismatch("result beat with nothing expected");
         end else begin
            want = expected_beats.pop_front();
            compare_field("read_data", rsp_read_data, want.read_data);
            compare_field("status", rsp_status, want.status);
            compare_field("level", rsp_level, want.level);
            compare_field("empty_res", rsp_empty_res, want.empty_res);
            compare_field("full_res", rsp_full_res, want.full_res);
            compare_field("last", rsp_last, want.last);
         end
         beats_checked++;
      end
   end

   task automatic test_empty_queue();
      send_cmd(brq_pkg::CMD_READ, 8'h00, 9'd1, 8'd0);
      send_cmd(brq_pkg::CMD_READ, 8'h00, 9'd0, 8'd0);
      send_cmd(brq_pkg::CMD_PEEK, 8'h00, 9'd0, 8'd0);
      send_cmd(brq_pkg::CMD_COPY, 8'h00, 9'd3, 8'd254);
      send_cmd(brq_pkg::CMD_DISCARD, 8'h00, 9'd0, 8'd0);
      send_cmd(brq_pkg::CMD_DISCARD, 8'h00, 9'd1, 8'd0);
   endtask

   task automatic test_write_bursts();
      send_cmd(brq_pkg::CMD_WRITE, 8'h00, 9'd3, 8'd0);
      send_cmd(brq_pkg::CMD_WRITE, 8'hff, 9'd3, 8'd1);
      send_cmd(brq_pkg::CMD_WRITE, 8'ha5, 9'd3, 8'd2);
      // byte past the burst length
      send_cmd(brq_pkg::CMD_WRITE, 8'h5a, 9'd3, 8'd3);
      send_cmd(brq_pkg::CMD_WRITE, 8'h11, 9'd0, 8'd0);
      // refused burst and its trailing byte
      send_cmd(brq_pkg::CMD_WRITE, 8'h22, 9'd256, 8'd0);
      send_cmd(brq_pkg::CMD_WRITE, 8'h33, 9'd256, 8'd1);
   endtask

   task automatic test_peek_copy_read();
      send_cmd(brq_pkg::CMD_PEEK, 8'h00, 9'd0, 8'd0);
      send_cmd(brq_pkg::CMD_PEEK, 8'h00, 9'd0, 8'd2);
      send_cmd(brq_pkg::CMD_PEEK, 8'h00, 9'd0, 8'd3);
      send_cmd(brq_pkg::CMD_PEEK, 8'h00, 9'd0, 8'd255);
      send_cmd(brq_pkg::CMD_COPY, 8'h00, 9'd2, 8'd1);
      send_cmd(brq_pkg::CMD_COPY, 8'h00, 9'd65, 8'd0);
      send_cmd(brq_pkg::CMD_COPY, 8'h00, 9'd256, 8'd255);
      send_cmd(brq_pkg::CMD_READ, 8'h00, 9'd65, 8'd0);
      send_cmd(brq_pkg::CMD_READ, 8'h00, 9'd4, 8'd0);
      send_cmd(brq_pkg::CMD_READ, 8'h00, 9'd2, 8'd0);
      send_cmd(brq_pkg::CMD_DISCARD, 8'h00, 9'd2, 8'd0);
      send_cmd(brq_pkg::CMD_DISCARD, 8'h00, 9'd1, 8'd0);
   endtask

   task automatic test_unused_commands();
      int c;
      for (c = CMD_FIRST_UNUSED; c <= CMD_MAX_CODE; c++) begin
         send_cmd(3'(c), 8'hff, 9'd256, 8'd255);
      end
   endtask

   task automatic test_full_queue();
      int need;
      int k;
      need = RING_DEPTH - ring_fill;
      for (k = 0; k < need; k++) begin
         send_cmd(brq_pkg::CMD_WRITE, 8'($urandom), 9'(need), 8'(k));
      end
      // burst still open but no room left
      send_cmd(brq_pkg::CMD_WRITE, 8'($urandom), 9'(need), 8'd1);
      send_cmd(brq_pkg::CMD_WRITE, 8'($urandom), 9'd1, 8'd0);
      send_cmd(brq_pkg::CMD_PEEK, 8'h00, 9'd0, 8'd255);
      send_cmd(brq_pkg::CMD_PEEK, 8'h00, 9'd0, 8'd0);
      send_cmd(brq_pkg::CMD_COPY, 8'h00, 9'd64, 8'd255);
      send_cmd(brq_pkg::CMD_READ, 8'h00, 9'd64, 8'd0);
      send_cmd(brq_pkg::CMD_DISCARD, 8'h00, 9'(ring_fill), 8'd0);
      send_cmd(brq_pkg::CMD_READ, 8'h00, 9'd1, 8'd0);
   endtask

   task automatic test_random_traffic(input int n_items);
      int stop_at;
      int pick;
      int shape;
      int len;
      int sent;
      int first;
      int k;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         shape = $urandom_range(99);
         if (pick < 45) begin
            sent = 0;
            if (shape < 70) begin
               len = $urandom_range(16, 1);
               sent = len;
            end else if (shape < 88) begin
               len = $urandom_range(BURST_MAX, 17);
               sent = len;
            end else if (shape < 94) begin
               // burst that does not fit, only its first few bytes are sent
               len = RING_DEPTH - ring_fill + $urandom_range(8, 1);
               if (len > RING_DEPTH) len = RING_DEPTH;
               sent = (len < 6) ? len : 6;
            end else begin
               len = 0;
               sent = 1;
            end
            first = ($urandom_range(9) == 0) ? 1 : 0;
            for (k = first; k < sent; k++) begin
               send_cmd(brq_pkg::CMD_WRITE, 8'($urandom), 9'(len), 8'(k));
            end
            if ($urandom_range(9) == 0) begin
               send_cmd(brq_pkg::CMD_WRITE, 8'($urandom), 9'(len),
                        8'($urandom_range((len > 255) ? 255 : len, 1)));
            end
         end else if (pick < 63) begin
            if (shape < 60 && ring_fill > 0) begin
               len = $urandom_range((ring_fill < BURST_MAX) ? ring_fill : BURST_MAX, 1);
            end else if (shape < 70) begin
               len = 0;
            end else if (shape < 85) begin
               len = ring_fill + $urandom_range(4, 1);
            end else begin
               len = $urandom_range(RING_DEPTH, BURST_MAX + 1);
            end
            if (len > RING_DEPTH) len = RING_DEPTH;
            send_cmd(brq_pkg::CMD_READ, 8'($urandom), 9'(len), 8'($urandom));
         end else if (pick < 70) begin
            if (shape < 70) len = $urandom_range((ring_fill < 8) ? ring_fill : 8, 0);
            else if (shape < 85) len = ring_fill;
            else len = ring_fill + $urandom_range(5, 1);
            if (len > RING_DEPTH) len = RING_DEPTH;
            send_cmd(brq_pkg::CMD_DISCARD, 8'($urandom), 9'(len), 8'($urandom));
         end else if (pick < 84) begin
            if (shape < 75 && ring_fill > 0) len = $urandom_range(ring_fill - 1, 0);
            else len = $urandom_range(255);
            send_cmd(brq_pkg::CMD_PEEK, 8'($urandom), 9'($urandom_range(RING_DEPTH)),
                     8'(len));
         end else if (pick < 96) begin
            if (shape < 70) len = $urandom_range(16, 1);
            else if (shape < 85) len = $urandom_range(BURST_MAX, 17);
            else if (shape < 90) len = 0;
            else len = $urandom_range(RING_DEPTH, BURST_MAX + 1);
            send_cmd(brq_pkg::CMD_COPY, 8'($urandom), 9'(len), 8'($urandom));
         end else begin
            send_cmd(3'($urandom_range(CMD_MAX_CODE, CMD_FIRST_UNUSED)), 8'($urandom),
                     9'($urandom_range(RING_DEPTH)), 8'($urandom));
         end
      end
   endtask

   initial begin
      int k;
      reset = 1'b1;
      start = 1'b0;
      req_command = brq_pkg::CMD_WRITE;
      req_write_data = 8'h00;
      req_count = 9'd0;
      req_offset = 8'd0;
      for (k = 0; k < RING_DEPTH; k++) ring_mem[k] = 8'h00;
      ring_head = 0;
      ring_tail = 0;
      ring_fill = 0;
      burst_ok = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      sender_idle_pct = 0;
      test_empty_queue();
      test_write_bursts();
      test_peek_copy_read();
      test_unused_commands();
      test_full_queue();
      test_random_traffic(55);
      sender_idle_pct = 87;
      test_random_traffic(55);
      sender_idle_pct = 14;
      test_random_traffic(55);

      start <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_beats.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
